[rtl/tsrr_pkg.sv]
`default_nettype none

package tsrr_pkg;

  localparam int NumSlots  = 4;
  localparam int IdWidth   = 16;
  localparam int PosWidth  = 2;
  localparam int SlotWidth = 2;
  localparam int CfgIdxW   = 3;

  // Control states
  typedef enum logic [2:0] {
    ST_FREE    = 3'd0,
    ST_WACK    = 3'd1,
    ST_WCOMMIT = 3'd2,
    ST_WAGREE  = 3'd3,
    ST_RESV    = 3'd4,
    ST_TRANSIT = 3'd5
  } state_e;

  // Received message kinds
  localparam logic [2:0] ACT_REQ    = 3'd0;
  localparam logic [2:0] ACT_ACK    = 3'd1;
  localparam logic [2:0] ACT_NACK   = 3'd2;
  localparam logic [2:0] ACT_COMMIT = 3'd3;
  localparam logic [2:0] ACT_AGREE  = 3'd4;
  localparam logic [2:0] ACT_DIS    = 3'd5;
  localparam logic [2:0] ACT_SENSOR = 3'd6;

  // Emitted message kinds
  localparam logic [3:0] K_REQ    = 4'd0;
  localparam logic [3:0] K_ACK    = 4'd1;
  localparam logic [3:0] K_NACK   = 4'd2;
  localparam logic [3:0] K_COMMIT = 4'd3;
  localparam logic [3:0] K_AGREE  = 4'd4;
  localparam logic [3:0] K_DIS    = 4'd5;
  localparam logic [3:0] K_TOK    = 4'd6;
  localparam logic [3:0] K_TNOK   = 4'd7;
  localparam logic [3:0] K_SENSE  = 4'd8;

  // Destinations
  localparam logic [1:0] TO_NEXT = 2'd0;
  localparam logic [1:0] TO_PREV = 2'd1;
  localparam logic [1:0] TO_SENS = 2'd2;

  // Node positions
  localparam logic [1:0] POS_UNUSED = 2'd0;
  localparam logic [1:0] POS_FIRST  = 2'd1;
  localparam logic [1:0] POS_LAST   = 2'd3;

  // Register indexes
  localparam logic [2:0] REG_ID_A  = 3'd0;
  localparam logic [2:0] REG_ID_B  = 3'd1;
  localparam logic [2:0] REG_ID_C  = 3'd2;
  localparam logic [2:0] REG_ID_D  = 3'd3;
  localparam logic [2:0] REG_POS_A = 3'd4;
  localparam logic [2:0] REG_POS_B = 3'd5;
  localparam logic [2:0] REG_POS_C = 3'd6;
  localparam logic [2:0] REG_POS_D = 3'd7;

  typedef struct packed {
    logic [2:0]         action;
    logic [IdWidth-1:0] route_id;
    logic               sensor_on;
  } in_word_t;

  typedef struct packed {
    logic [3:0]         msg_kind;
    logic [1:0]         toward;
    logic [IdWidth-1:0] out_route_id;
    logic               want_on;
    logic               last;
  } out_word_t;

  // Results handed from the controller to the output queue
  typedef struct packed {
    logic [1:0] cnt;
    out_word_t  r0;
    out_word_t  r1;
  } push_t;

endpackage

`default_nettype wire

[rtl/tsrr_cfg.sv]
`default_nettype none

module tsrr_cfg (
  input  logic                                                   clk_i,
  input  logic                                                   rst_ni,
  input  logic                                                   cfg_we_i,
  input  logic [tsrr_pkg::CfgIdxW-1:0]                           cfg_idx_i,
  input  logic [tsrr_pkg::IdWidth-1:0]                           cfg_data_i,
  output logic [tsrr_pkg::NumSlots-1:0][tsrr_pkg::IdWidth-1:0]   id_o,
  output logic [tsrr_pkg::NumSlots-1:0][tsrr_pkg::PosWidth-1:0]  pos_o
);

  logic [tsrr_pkg::NumSlots-1:0][tsrr_pkg::IdWidth-1:0]  id_q, id_d;
  logic [tsrr_pkg::NumSlots-1:0][tsrr_pkg::PosWidth-1:0] pos_q, pos_d;

  always_comb begin
    id_d  = id_q;
    pos_d = pos_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tsrr_pkg::REG_ID_A:  id_d[0]  = cfg_data_i;
        tsrr_pkg::REG_ID_B:  id_d[1]  = cfg_data_i;
        tsrr_pkg::REG_ID_C:  id_d[2]  = cfg_data_i;
        tsrr_pkg::REG_ID_D:  id_d[3]  = cfg_data_i;
        tsrr_pkg::REG_POS_A: pos_d[0] = cfg_data_i[tsrr_pkg::PosWidth-1:0];
        tsrr_pkg::REG_POS_B: pos_d[1] = cfg_data_i[tsrr_pkg::PosWidth-1:0];
        tsrr_pkg::REG_POS_C: pos_d[2] = cfg_data_i[tsrr_pkg::PosWidth-1:0];
        tsrr_pkg::REG_POS_D: pos_d[3] = cfg_data_i[tsrr_pkg::PosWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_q  <= '0;
      pos_q <= '0;
    end else begin
      id_q  <= id_d;
      pos_q <= pos_d;
    end
  end

  assign id_o  = id_q;
  assign pos_o = pos_q;

endmodule

`default_nettype wire

[rtl/tsrr_ctrl.sv]
`default_nettype none

module tsrr_ctrl (
  input  logic                                                   clk_i,
  input  logic                                                   rst_ni,
  input  logic                                                   valid_i,
  input  tsrr_pkg::in_word_t                                     word_i,
  input  logic [1:0]                                             free_i,
  input  logic [tsrr_pkg::NumSlots-1:0][tsrr_pkg::IdWidth-1:0]   id_i,
  input  logic [tsrr_pkg::NumSlots-1:0][tsrr_pkg::PosWidth-1:0]  pos_i,
  output logic                                                   consume_o,
  output tsrr_pkg::push_t                                        push_o
);

  tsrr_pkg::state_e                state_q, state_d;
  logic [tsrr_pkg::SlotWidth-1:0]  slot_q, slot_d;

  logic [tsrr_pkg::PosWidth-1:0]   pos;
  logic                            match;
  logic                            found;
  logic [tsrr_pkg::SlotWidth-1:0]  fslot;
  logic [tsrr_pkg::SlotWidth-1:0]  emit_slot;
  logic [1:0]                      n_res;
  logic [3:0]                      k0, k1;
  logic [1:0]                      t0, t1;
  logic                            on1;

  assign pos   = pos_i[slot_q];
  assign match = (word_i.route_id == id_i[slot_q]);

  // Priority search: lowest configured slot with matching id wins
  always_comb begin
    found = 1'b0;
    fslot = '0;
    for (int i = tsrr_pkg::NumSlots - 1; i >= 0; i--) begin
      if (pos_i[i] != tsrr_pkg::POS_UNUSED && id_i[i] == word_i.route_id) begin
        found = 1'b1;
        fslot = tsrr_pkg::SlotWidth'(i);
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    slot_d  = slot_q;
    unique case (state_q)
      tsrr_pkg::ST_WACK: begin
        if (word_i.action == tsrr_pkg::ACT_ACK && match) begin
          state_d = (pos == tsrr_pkg::POS_FIRST) ? tsrr_pkg::ST_WAGREE : tsrr_pkg::ST_WCOMMIT;
        end else if (word_i.action == tsrr_pkg::ACT_NACK && match) begin
          state_d = tsrr_pkg::ST_FREE;
          slot_d  = '0;
        end
      end
      tsrr_pkg::ST_WCOMMIT: begin
        if (word_i.action == tsrr_pkg::ACT_COMMIT && match) begin
          state_d = (pos == tsrr_pkg::POS_LAST) ? tsrr_pkg::ST_RESV : tsrr_pkg::ST_WAGREE;
        end else if (word_i.action == tsrr_pkg::ACT_DIS && match) begin
          state_d = tsrr_pkg::ST_FREE;
          slot_d  = '0;
        end
      end
      tsrr_pkg::ST_WAGREE: begin
        if (word_i.action == tsrr_pkg::ACT_AGREE && match) begin
          state_d = tsrr_pkg::ST_RESV;
        end else if (word_i.action == tsrr_pkg::ACT_DIS && match) begin
          state_d = tsrr_pkg::ST_FREE;
          slot_d  = '0;
        end
      end
      tsrr_pkg::ST_RESV: begin
        if (word_i.action == tsrr_pkg::ACT_SENSOR && word_i.sensor_on) begin
          state_d = tsrr_pkg::ST_TRANSIT;
        end else if (word_i.action == tsrr_pkg::ACT_DIS && match) begin
          state_d = tsrr_pkg::ST_FREE;
          slot_d  = '0;
        end
      end
      tsrr_pkg::ST_TRANSIT: begin
        if (word_i.action == tsrr_pkg::ACT_SENSOR && !word_i.sensor_on) begin
          state_d = tsrr_pkg::ST_FREE;
          slot_d  = '0;
        end
      end
      default: begin
        if (word_i.action == tsrr_pkg::ACT_REQ) begin
          if (found) begin
            slot_d  = fslot;
            state_d = (pos_i[fslot] == tsrr_pkg::POS_LAST) ? tsrr_pkg::ST_WCOMMIT
                                                           : tsrr_pkg::ST_WACK;
          end
        end else begin
          state_d = tsrr_pkg::ST_FREE;
        end
      end
    endcase
  end

  // Outputs: up to two messages
  always_comb begin
    n_res     = 2'd0;
    k0        = tsrr_pkg::K_REQ;
    t0        = tsrr_pkg::TO_NEXT;
    k1        = tsrr_pkg::K_SENSE;
    t1        = tsrr_pkg::TO_SENS;
    on1       = 1'b0;
    emit_slot = slot_q;
    unique case (state_q)
      tsrr_pkg::ST_WACK: begin
        if (word_i.action == tsrr_pkg::ACT_ACK && match) begin
          n_res = 2'd1;
          if (pos == tsrr_pkg::POS_FIRST) begin
            k0 = tsrr_pkg::K_COMMIT;
            t0 = tsrr_pkg::TO_NEXT;
          end else begin
            k0 = tsrr_pkg::K_ACK;
            t0 = tsrr_pkg::TO_PREV;
          end
        end else if (word_i.action == tsrr_pkg::ACT_NACK && match) begin
          n_res = 2'd1;
          k0    = (pos == tsrr_pkg::POS_FIRST) ? tsrr_pkg::K_TNOK : tsrr_pkg::K_NACK;
          t0    = tsrr_pkg::TO_PREV;
        end
      end
      tsrr_pkg::ST_WCOMMIT: begin
        if (word_i.action == tsrr_pkg::ACT_COMMIT && match) begin
          if (pos == tsrr_pkg::POS_LAST) begin
            n_res = 2'd2;
            k0    = tsrr_pkg::K_AGREE;
            t0    = tsrr_pkg::TO_PREV;
            on1   = 1'b1;
          end else begin
            n_res = 2'd1;
            k0    = tsrr_pkg::K_COMMIT;
            t0    = tsrr_pkg::TO_NEXT;
          end
        end else if (word_i.action == tsrr_pkg::ACT_DIS && match
                     && pos != tsrr_pkg::POS_LAST) begin
          n_res = 2'd1;
          k0    = tsrr_pkg::K_DIS;
          t0    = tsrr_pkg::TO_NEXT;
        end
      end
      tsrr_pkg::ST_WAGREE: begin
        if (word_i.action == tsrr_pkg::ACT_AGREE && match) begin
          n_res = 2'd2;
          k0    = (pos == tsrr_pkg::POS_FIRST) ? tsrr_pkg::K_TOK : tsrr_pkg::K_AGREE;
          t0    = tsrr_pkg::TO_PREV;
          on1   = 1'b1;
        end else if (word_i.action == tsrr_pkg::ACT_DIS && match) begin
          n_res = 2'd1;
          k0    = (pos == tsrr_pkg::POS_FIRST) ? tsrr_pkg::K_TNOK : tsrr_pkg::K_DIS;
          t0    = tsrr_pkg::TO_PREV;
        end
      end
      tsrr_pkg::ST_RESV: begin
        if (word_i.action == tsrr_pkg::ACT_SENSOR && word_i.sensor_on) begin
          n_res = 2'd1;
          k0    = tsrr_pkg::K_SENSE;
          t0    = tsrr_pkg::TO_SENS;
        end else if (word_i.action == tsrr_pkg::ACT_DIS && match
                     && pos != tsrr_pkg::POS_LAST) begin
          n_res = 2'd1;
          k0    = tsrr_pkg::K_DIS;
          t0    = tsrr_pkg::TO_NEXT;
        end
      end
      tsrr_pkg::ST_TRANSIT: ;
      default: begin
        if (word_i.action == tsrr_pkg::ACT_REQ && found) begin
          n_res     = 2'd1;
          emit_slot = fslot;
          if (pos_i[fslot] == tsrr_pkg::POS_LAST) begin
            k0 = tsrr_pkg::K_ACK;
            t0 = tsrr_pkg::TO_PREV;
          end else begin
            k0 = tsrr_pkg::K_REQ;
            t0 = tsrr_pkg::TO_NEXT;
          end
        end
      end
    endcase
  end

  // Take the word only when the queue has room for all its results
  assign consume_o = valid_i && (free_i >= n_res);

  always_comb begin
    push_o                 = '0;
    push_o.cnt             = consume_o ? n_res : 2'd0;
    push_o.r0.msg_kind     = k0;
    push_o.r0.toward       = t0;
    push_o.r0.out_route_id = id_i[emit_slot];
    push_o.r0.want_on      = 1'b0;
    push_o.r0.last         = (n_res == 2'd1);
    push_o.r1.msg_kind     = k1;
    push_o.r1.toward       = t1;
    push_o.r1.out_route_id = id_i[emit_slot];
    push_o.r1.want_on      = on1;
    push_o.r1.last         = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsrr_pkg::ST_FREE;
      slot_q  <= '0;
    end else if (consume_o) begin
      state_q <= state_d;
      slot_q  <= slot_d;
    end
  end

endmodule

`default_nettype wire

[rtl/tsrr_outq.sv]
`default_nettype none

module tsrr_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tsrr_pkg::push_t     push_i,
  output logic [1:0]          free_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tsrr_pkg::out_word_t out_word_o
);

  // Two-entry queue, entry 0 is the head
  logic [1:0]          cnt_q, cnt_d;
  tsrr_pkg::out_word_t e0_q, e0_d, e1_q, e1_d;
  logic                pop;
  logic [1:0]          base;

  assign pop    = (cnt_q != 2'd0) && !out_stall_i;
  assign base   = cnt_q - {1'b0, pop};
  assign free_o = 2'd2 - base;

  always_comb begin
    e0_d = e0_q;
    e1_d = e1_q;
    if (pop) begin
      e0_d = e1_q;
    end
    if (push_i.cnt != 2'd0) begin
      if (base == 2'd0) begin
        e0_d = push_i.r0;
      end else begin
        e1_d = push_i.r0;
      end
    end
    if (push_i.cnt == 2'd2) begin
      e1_d = push_i.r1;
    end
    cnt_d = base + push_i.cnt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e0_q <= e0_d;
    e1_q <= e1_d;
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_word_o  = e0_q;

endmodule

`default_nettype wire

[rtl/track_section_route_reservation.sv]
`default_nettype none

// Channel   Direction  Handshake               Word
// input     in         in_valid_i / in_stall_o   tsrr_pkg::in_word_t
// output    out        out_valid_o / out_stall_i tsrr_pkg::out_word_t
// config    in         cfg_we_i (no stall)       cfg_idx_i, cfg_data_i
//
// Flow: a word is held in the input register, then the controller decides
// and pushes its zero, one or two results into a two-entry output queue.
// Words with at most one result go at one per cycle while the output is not
// stalled; a two-result word needs the whole queue free (one read port).
// Reset: async, active low; state returns to not reserved, slot 0, config 0.
// Stalls: the input register holds while the queue lacks room for all of
// a word's results; a draining queue entry counts as room the same cycle.

module track_section_route_reservation (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  tsrr_pkg::in_word_t                in_word_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output tsrr_pkg::out_word_t               out_word_o,
  input  logic                              cfg_we_i,
  input  logic [tsrr_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [tsrr_pkg::IdWidth-1:0]      cfg_data_i
);

  logic                                                  in_valid_q, in_valid_d;
  tsrr_pkg::in_word_t                                    in_word_q;
  logic                                                  in_take;
  logic                                                  consume;
  logic [1:0]                                            free;
  tsrr_pkg::push_t                                       push;
  logic [tsrr_pkg::NumSlots-1:0][tsrr_pkg::IdWidth-1:0]  cfg_id;
  logic [tsrr_pkg::NumSlots-1:0][tsrr_pkg::PosWidth-1:0] cfg_pos;

  // Input register: refills in the same cycle it is consumed
  assign in_stall_o = in_valid_q && !consume;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (consume) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_word_q <= in_word_i;
    end
  end

  // Route slot registers, read live by the controller
  tsrr_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .id_o       (cfg_id),
    .pos_o      (cfg_pos)
  );

  // Handshake state machine and message builder
  tsrr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_q),
    .word_i    (in_word_q),
    .free_i    (free),
    .id_i      (cfg_id),
    .pos_i     (cfg_pos),
    .consume_o (consume),
    .push_o    (push)
  );

  // Result queue toward the output channel
  tsrr_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

[tb/tb.sv]
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tsrr_pkg::*;

  // Position code for a middle node; the package names only the others.
  localparam logic [PosWidth-1:0] POS_MIDDLE = 2'd2;

  // Node view kept by the testbench: the live register contents plus the
  // handshake state and the slot held by the current reservation.
  typedef struct packed {
    logic [NumSlots-1:0][IdWidth-1:0]  id;
    logic [NumSlots-1:0][PosWidth-1:0] pos;
    state_e                            st;
    logic [SlotWidth-1:0]              slot;
  } node_t;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  in_word_t              in_word_i  = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_word_t             out_word_o;
  logic                  cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]    cfg_idx_i  = '0;
  logic [IdWidth-1:0]    cfg_data_i = '0;

  track_section_route_reservation dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // live_node follows the block word by word as words are accepted;
  // plan_node runs ahead while stimulus is built, so the generator knows
  // which message moves the handshake on.
  node_t     live_node = '0;
  node_t     plan_node = '0;
  in_word_t  rx_words[$];      // words waiting to be driven
  out_word_t due_msgs[$];      // messages the block still owes
  int        fails = 0;

  // Per-word handshake bookkeeping between the posedge and negedge blocks.
  bit        word_taken   = 1'b0;
  bit        msg_taken    = 1'b0;
  int        send_gap     = 0;
  int        stall_left   = 0;
  bit        send_quiet   = 1'b0;
  bit        stall_quiet  = 1'b0;
  out_word_t got0, got1, exp_msg;
  int        got_n;

  function automatic out_word_t make_msg(node_t n, logic [3:0] kind, logic [1:0] dest,
                                         logic on);
    out_word_t m;
    m.msg_kind     = kind;
    m.toward       = dest;
    m.out_route_id = n.id[n.slot];   // id of the held slot, read before release
    m.want_on      = on;
    m.last         = 1'b1;
    return m;
  endfunction

  // One received message through the reservation handshake. Returns up to
  // two outgoing messages in order; last is set on the final one only.
  function automatic void advance_reservation(inout node_t n, input in_word_t w,
                                              output out_word_t m0, output out_word_t m1,
                                              output int cnt);
    logic [PosWidth-1:0] p;
    logic                hit;
    bit                  found;
    int                  i;
    p     = n.pos[n.slot];
    hit   = (w.route_id == n.id[n.slot]);
    found = 1'b0;
    cnt   = 0;
    m0    = '0;
    m1    = '0;
    case (n.st)
      ST_WACK: begin
        if (w.action == ACT_ACK && hit) begin
          // a last position here behaves as middle
          if (p == POS_FIRST) begin
            n.st = ST_WAGREE;
            m0   = make_msg(n, K_COMMIT, TO_NEXT, 1'b0);
          end else begin
            n.st = ST_WCOMMIT;
            m0   = make_msg(n, K_ACK, TO_PREV, 1'b0);
          end
          cnt = 1;
        end else if (w.action == ACT_NACK && hit) begin
          m0     = make_msg(n, (p == POS_FIRST) ? K_TNOK : K_NACK, TO_PREV, 1'b0);
          cnt    = 1;
          n.st   = ST_FREE;
          n.slot = '0;
        end
      end
      ST_WCOMMIT: begin
        if (w.action == ACT_COMMIT && hit) begin
          if (p == POS_LAST) begin
            n.st = ST_RESV;
            m0   = make_msg(n, K_AGREE, TO_PREV, 1'b0);
            m1   = make_msg(n, K_SENSE, TO_SENS, 1'b1);
            cnt  = 2;
          end else begin
            // first position here behaves as middle
            n.st = ST_WAGREE;
            m0   = make_msg(n, K_COMMIT, TO_NEXT, 1'b0);
            cnt  = 1;
          end
        end else if (w.action == ACT_DIS && hit) begin
          if (p != POS_LAST) begin
            m0  = make_msg(n, K_DIS, TO_NEXT, 1'b0);
            cnt = 1;
          end
          n.st   = ST_FREE;
          n.slot = '0;
        end
      end
      ST_WAGREE: begin
        if (w.action == ACT_AGREE && hit) begin
          n.st = ST_RESV;
          m0   = make_msg(n, (p == POS_FIRST) ? K_TOK : K_AGREE, TO_PREV, 1'b0);
          m1   = make_msg(n, K_SENSE, TO_SENS, 1'b1);
          cnt  = 2;
        end else if (w.action == ACT_DIS && hit) begin
          m0     = make_msg(n, (p == POS_FIRST) ? K_TNOK : K_DIS, TO_PREV, 1'b0);
          cnt    = 1;
          n.st   = ST_FREE;
          n.slot = '0;
        end
      end
      ST_RESV: begin
        if (w.action == ACT_SENSOR && w.sensor_on) begin
          n.st = ST_TRANSIT;
          m0   = make_msg(n, K_SENSE, TO_SENS, 1'b0);
          cnt  = 1;
        end else if (w.action == ACT_DIS && hit) begin
          if (p != POS_LAST) begin
            m0  = make_msg(n, K_DIS, TO_NEXT, 1'b0);
            cnt = 1;
          end
          n.st   = ST_FREE;
          n.slot = '0;
        end
      end
      ST_TRANSIT: begin
        if (w.action == ACT_SENSOR && !w.sensor_on) begin
          n.st   = ST_FREE;
          n.slot = '0;
        end
      end
      default: begin
        if (w.action == ACT_REQ) begin
          // lowest configured slot with a matching id wins
          for (i = 0; i < NumSlots; i++) begin
            if (!found && n.pos[i] != POS_UNUSED && n.id[i] == w.route_id) begin
              found  = 1'b1;
              n.slot = SlotWidth'(i);
              if (n.pos[i] == POS_LAST) begin
                n.st = ST_WCOMMIT;
                m0   = make_msg(n, K_ACK, TO_PREV, 1'b0);
              end else begin
                n.st = ST_WACK;
                m0   = make_msg(n, K_REQ, TO_NEXT, 1'b0);
              end
              cnt = 1;
            end
          end
        end else begin
          n.st = ST_FREE;
        end
      end
    endcase
    if (cnt == 2) m0.last = 1'b0;
  endfunction

  function automatic in_word_t word_of(logic [2:0] act, logic [IdWidth-1:0] rid, logic son);
    in_word_t w;
    w.action    = act;
    w.route_id  = rid;
    w.sensor_on = son;
    return w;
  endfunction

  // Queue a word for the driver and step the planning copy. Returns 1 if
  // the word does anything (a message or a state change).
  function automatic bit queue_word(in_word_t w);
    node_t     prior;
    out_word_t m0, m1;
    int        cnt;
    prior = plan_node;
    advance_reservation(plan_node, w, m0, m1, cnt);
    rx_words.push_back(w);
    return (cnt > 0) || (plan_node != prior);
  endfunction

  // Mostly the message that moves the handshake on, with random ids where
  // the state ignores them; about one word in eight is pure noise.
  function automatic in_word_t next_message(node_t g);
    in_word_t w;
    int       s;
    int       tries;
    w.action    = ACT_REQ;
    w.route_id  = g.id[g.slot];
    w.sensor_on = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 12) begin
      w.action   = 3'($urandom_range(0, 7));
      w.route_id = $urandom_range(0, 1) ? g.id[$urandom_range(0, 3)] : IdWidth'($urandom);
      return w;
    end
    case (g.st)
      ST_WACK:    w.action = ($urandom_range(0, 99) < 75) ? ACT_ACK : ACT_NACK;
      ST_WCOMMIT: w.action = ($urandom_range(0, 99) < 80) ? ACT_COMMIT : ACT_DIS;
      ST_WAGREE:  w.action = ($urandom_range(0, 99) < 80) ? ACT_AGREE : ACT_DIS;
      ST_RESV: begin
        if ($urandom_range(0, 99) < 80) begin
          w.action    = ACT_SENSOR;
          w.sensor_on = 1'b1;
          w.route_id  = IdWidth'($urandom);
        end else begin
          w.action = ACT_DIS;
        end
      end
      ST_TRANSIT: begin
        w.action    = ACT_SENSOR;
        w.sensor_on = 1'b0;
        w.route_id  = IdWidth'($urandom);
      end
      default: begin
        s = $urandom_range(0, 3);
        for (tries = 0; tries < 8 && g.pos[s] == POS_UNUSED; tries++)
          s = $urandom_range(0, 3);
        w.route_id = (g.pos[s] != POS_UNUSED) ? g.id[s] : IdWidth'($urandom);
      end
    endcase
    return w;
  endfunction

  // Register writes happen only with the block idle; both node copies
  // take the new value at once.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [IdWidth-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx < REG_POS_A) begin
      live_node.id[2'(idx - REG_ID_A)] = data;
      plan_node.id[2'(idx - REG_ID_A)] = data;
    end else begin
      live_node.pos[2'(idx - REG_POS_A)] = data[PosWidth-1:0];
      plan_node.pos[2'(idx - REG_POS_A)] = data[PosWidth-1:0];
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Drain: all words sent, all messages seen, then a wait so that a word
  // that makes no message can leave the pipeline.
  task automatic wait_idle();
    while (rx_words.size() != 0 || in_valid_i || due_msgs.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic run_phase(input int target);
    int done;
    int tries;
    done  = 0;
    tries = 0;
    while (done < target && tries < target * 4) begin
      if (queue_word(next_message(plan_node))) done++;
      tries++;
    end
    wait_idle();
  endtask

  // Acceptance on both channels, sampled at the rising edge. Words are
  // predicted as they are taken; messages are checked against the oldest
  // one owed.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      advance_reservation(live_node, in_word_i, got0, got1, got_n);
      if (got_n > 0) due_msgs.push_back(got0);
      if (got_n > 1) due_msgs.push_back(got1);
      word_taken = 1'b1;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      msg_taken = 1'b1;
      if (due_msgs.size() == 0) begin
        $error("unexpected message: kind %0d toward %0d route %h",
               out_word_o.msg_kind, out_word_o.toward, out_word_o.out_route_id);
        fails++;
      end else begin
        exp_msg = due_msgs.pop_front();
        if (out_word_o.msg_kind !== exp_msg.msg_kind) begin
          $error("msg_kind: expected %0d, got %0d", exp_msg.msg_kind, out_word_o.msg_kind);
          fails++;
        end
        if (out_word_o.toward !== exp_msg.toward) begin
          $error("toward: expected %0d, got %0d", exp_msg.toward, out_word_o.toward);
          fails++;
        end
        if (out_word_o.out_route_id !== exp_msg.out_route_id) begin
          $error("out_route_id: expected %h, got %h",
                 exp_msg.out_route_id, out_word_o.out_route_id);
          fails++;
        end
        if (out_word_o.want_on !== exp_msg.want_on) begin
          $error("want_on: expected %0d, got %0d", exp_msg.want_on, out_word_o.want_on);
          fails++;
        end
        if (out_word_o.last !== exp_msg.last) begin
          $error("last: expected %0d, got %0d", exp_msg.last, out_word_o.last);
          fails++;
        end
      end
    end
  end

  // Word driver: holds a stalled word, then waits a random gap before the
  // next one. Gaps go to zero for stretches so back-to-back traffic occurs.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || word_taken)) begin
      word_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (rx_words.size() != 0) begin
        in_word_i  <= rx_words.pop_front();
        in_valid_i <= 1'b1;
        if ($urandom_range(0, 31) == 0) send_quiet = ~send_quiet;
        send_gap = send_quiet ? 0 : $urandom_range(0, 11);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Message sink: after each message taken, stall for a random count.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (msg_taken) begin
        msg_taken = 1'b0;
        if ($urandom_range(0, 31) == 0) stall_quiet = ~stall_quiet;
        stall_left = stall_quiet ? 0 : $urandom_range(0, 11);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    logic [IdWidth-1:0]  rid;
    logic [IdWidth-1:0]  data;
    logic [PosWidth-1:0] rpos;
    logic [IdWidth-1:0]  ids [NumSlots];
    int                  ph;
    int                  i;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed setup: slot A first on id 0, slot B last on id FFFF,
    // slot C unused and slot D middle, both on 1234 so the unused one
    // must be skipped.
    write_reg(REG_ID_A, 16'h0000);
    write_reg(REG_ID_B, 16'hFFFF);
    write_reg(REG_ID_C, 16'h1234);
    write_reg(REG_ID_D, 16'h1234);
    write_reg(REG_POS_A, 16'(POS_FIRST));
    write_reg(REG_POS_B, 16'(POS_LAST));
    write_reg(REG_POS_C, 16'(POS_UNUSED));
    write_reg(REG_POS_D, 16'(POS_MIDDLE));

    // first node: full run through to the train passing
    void'(queue_word(word_of(ACT_REQ, 16'h0000, 1'b0)));
    void'(queue_word(word_of(ACT_ACK, 16'h5555, 1'b0)));     // wrong id, ignored
    void'(queue_word(word_of(ACT_ACK, 16'h0000, 1'b0)));
    void'(queue_word(word_of(ACT_AGREE, 16'h0000, 1'b1)));
    void'(queue_word(word_of(ACT_SENSOR, 16'hAAAA, 1'b0)));  // wrong polarity
    void'(queue_word(word_of(ACT_SENSOR, 16'h0000, 1'b1)));
    void'(queue_word(word_of(ACT_SENSOR, 16'hFFFF, 1'b0)));
    // last node: reserve, then cancel without a message onward
    void'(queue_word(word_of(ACT_REQ, 16'hFFFF, 1'b1)));
    void'(queue_word(word_of(ACT_COMMIT, 16'hFFFF, 1'b0)));
    void'(queue_word(word_of(ACT_DIS, 16'hFFFF, 1'b0)));
    // middle node: full handshake, cancelled while waiting for agree
    void'(queue_word(word_of(ACT_REQ, 16'h1234, 1'b0)));
    void'(queue_word(word_of(ACT_ACK, 16'h1234, 1'b0)));
    void'(queue_word(word_of(ACT_COMMIT, 16'h1234, 1'b0)));
    void'(queue_word(word_of(ACT_DIS, 16'h1234, 1'b0)));
    // refusals on first and middle
    void'(queue_word(word_of(ACT_REQ, 16'h0000, 1'b0)));
    void'(queue_word(word_of(ACT_NACK, 16'h0000, 1'b0)));
    void'(queue_word(word_of(ACT_REQ, 16'h1234, 1'b0)));
    void'(queue_word(word_of(ACT_NACK, 16'h1234, 1'b0)));
    // stray words while free, including the unused action code
    void'(queue_word(word_of(3'd7, 16'h0000, 1'b1)));
    void'(queue_word(word_of(ACT_ACK, 16'h0000, 1'b0)));
    // first node cancelled while waiting for agree
    void'(queue_word(word_of(ACT_REQ, 16'h0000, 1'b0)));
    void'(queue_word(word_of(ACT_ACK, 16'h0000, 1'b0)));
    void'(queue_word(word_of(ACT_DIS, 16'h0000, 1'b0)));
    // middle node cancelled from reserved
    void'(queue_word(word_of(ACT_REQ, 16'h1234, 1'b0)));
    void'(queue_word(word_of(ACT_ACK, 16'h1234, 1'b0)));
    void'(queue_word(word_of(ACT_COMMIT, 16'h1234, 1'b0)));
    void'(queue_word(word_of(ACT_AGREE, 16'h1234, 1'b0)));
    void'(queue_word(word_of(ACT_DIS, 16'h1234, 1'b0)));
    wait_idle();

    // Position changed under a held slot: first seen in wait commit acts
    // as middle.
    void'(queue_word(word_of(ACT_REQ, 16'hFFFF, 1'b0)));
    wait_idle();
    write_reg(REG_POS_B, 16'(POS_FIRST));
    void'(queue_word(word_of(ACT_COMMIT, 16'hFFFF, 1'b0)));
    void'(queue_word(word_of(ACT_AGREE, 16'hFFFF, 1'b0)));
    void'(queue_word(word_of(ACT_SENSOR, 16'h0000, 1'b1)));
    void'(queue_word(word_of(ACT_SENSOR, 16'h0000, 1'b0)));
    wait_idle();

    // Last seen in wait ack also acts as middle.
    void'(queue_word(word_of(ACT_REQ, 16'h0000, 1'b0)));
    wait_idle();
    write_reg(REG_POS_A, 16'(POS_LAST));
    void'(queue_word(word_of(ACT_ACK, 16'h0000, 1'b0)));
    void'(queue_word(word_of(ACT_COMMIT, 16'h0000, 1'b0)));
    void'(queue_word(word_of(ACT_DIS, 16'h0000, 1'b0)));
    wait_idle();

    // Random phases: all-FFFF last nodes, all-zero first nodes, no slot
    // in use, then mixed settings with repeated ids. State may carry over
    // a phase boundary, so held slots see their registers change.
    for (ph = 0; ph < 8; ph++) begin
      for (i = 0; i < NumSlots; i++) begin
        case (ph)
          0: begin
            rid  = 16'hFFFF;
            rpos = POS_LAST;
          end
          1: begin
            rid  = 16'h0000;
            rpos = POS_FIRST;
          end
          2: begin
            rid  = IdWidth'($urandom);
            rpos = POS_UNUSED;
          end
          default: begin
            if (i > 0 && $urandom_range(0, 2) == 0) rid = ids[$urandom_range(0, i - 1)];
            else rid = IdWidth'($urandom);
            rpos = PosWidth'($urandom_range(0, 3));
          end
        endcase
        ids[i] = rid;
        write_reg(REG_ID_A + CfgIdxW'(i), rid);
        // upper data bits are don't-care for a position register
        data       = IdWidth'($urandom);
        data[PosWidth-1:0] = rpos;
        write_reg(REG_POS_A + CfgIdxW'(i), data);
      end
      run_phase((ph == 2) ? 10 : 75);
    end

    wait_idle();
    repeat (16) @(posedge clk_i);
    if (fails == 0 && due_msgs.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #2000000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
rtl/tsrr_pkg.sv
rtl/tsrr_cfg.sv
rtl/tsrr_ctrl.sv
rtl/tsrr_outq.sv
rtl/track_section_route_reservation.sv
tb/tb.sv
